[src/power_key_idle_controller_macros.svh]
// -----------------------------------------------------------------------------
// Power key idle controller assertion macros
// Shared immediate-style wrappers around concurrent assertions.
// -----------------------------------------------------------------------------
`ifndef POWER_KEY_IDLE_CONTROLLER_MACROS_SVH
`define POWER_KEY_IDLE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PKC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pkc_pkg.sv]
// -----------------------------------------------------------------------------
// Power key idle controller package
// Event, result and configuration types plus shared codes.
// -----------------------------------------------------------------------------
package pkc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 16;

  // Event codes
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_POLL  = 2'd1;
  localparam logic [1:0] REQ_ACT   = 2'd2;
  localparam logic [1:0] REQ_SLEEP = 2'd3;

  // Press action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_SLEEP   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLEEP_POLLS    = 2'd0;
  localparam logic [1:0] CFG_RESTART_POLLS  = 2'd1;
  localparam logic [1:0] CFG_SHUTDOWN_POLLS = 2'd2;
  localparam logic [1:0] CFG_IDLE_TIMEOUT   = 2'd3;

  localparam logic [TIME_W-1:0] WAKE_WINDOW_MS = 32'd2000;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] now_ms;
    logic              key_down;
  } event_t;

  typedef struct packed {
    logic              display_on;
    logic              shutdown;
    logic [1:0]        press_action;
    logic              woke;
    logic [TIME_W-1:0] slept_ms;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sleep_press_polls;
    logic [CNT_W-1:0]  restart_press_polls;
    logic [CNT_W-1:0]  shutdown_press_polls;
    logic [TIME_W-1:0] idle_timeout_ms;
  } cfg_t;

endpackage

[src/pkc_if.sv]
// -----------------------------------------------------------------------------
// Power key idle controller channels
// Valid/ready interfaces for the event input and the result output.
// -----------------------------------------------------------------------------
interface pkc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic        key_down;

  modport source (output valid, output req_type, output now_ms, output key_down,
                  input ready);
  modport sink   (input valid, input req_type, input now_ms, input key_down,
                  output ready);
endinterface

interface pkc_out_if;
  logic        valid;
  logic        ready;
  logic        display_on;
  logic        shutdown;
  logic [1:0]  press_action;
  logic        woke;
  logic [31:0] slept_ms;

  modport source (output valid, output display_on, output shutdown,
                  output press_action, output woke, output slept_ms, input ready);
  modport sink   (input valid, input display_on, input shutdown,
                  input press_action, input woke, input slept_ms, output ready);
endinterface

[src/pkc_cfg_regs.sv]
// -----------------------------------------------------------------------------
// Configuration registers
// Write-only threshold and timeout registers.
// -----------------------------------------------------------------------------
module pkc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output pkc_pkg::cfg_t cfg
);
  import pkc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_press_polls    <= 16'd2;
      cfg_r.restart_press_polls  <= 16'd6;
      cfg_r.shutdown_press_polls <= 16'd10;
      cfg_r.idle_timeout_ms      <= 32'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLEEP_POLLS:    cfg_r.sleep_press_polls    <= cfg_data[CNT_W-1:0];
        CFG_RESTART_POLLS:  cfg_r.restart_press_polls  <= cfg_data[CNT_W-1:0];
        CFG_SHUTDOWN_POLLS: cfg_r.shutdown_press_polls <= cfg_data[CNT_W-1:0];
        CFG_IDLE_TIMEOUT:   cfg_r.idle_timeout_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/pkc_in_stage.sv]
// -----------------------------------------------------------------------------
// Event input register
// Captures one event per cycle while in_ready is high, ahead of the core.
// -----------------------------------------------------------------------------
module pkc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pkc_pkg::event_t ev_in,
  input  logic            advance,
  output logic            ev_valid,
  output pkc_pkg::event_t ev
);
  import pkc_pkg::*;

  logic   valid_r;
  event_t ev_r;

  // Free when empty or when the held event moves on this cycle.
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ev_r <= ev_in;
    end
  end

  assign ev_valid = valid_r;
  assign ev       = ev_r;

endmodule

[src/pkc_core.sv]
// -----------------------------------------------------------------------------
// Power key decision core
// Key guard, press counter, idle timer, sleep/wake and shutdown latch.
// -----------------------------------------------------------------------------
module pkc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  pkc_pkg::cfg_t    cfg,
  input  logic             fire,
  input  pkc_pkg::event_t  ev,
  output pkc_pkg::result_t res
);
  import pkc_pkg::*;

  typedef enum logic [1:0] {
    GUARD_IGNORE,
    GUARD_WAIT,
    GUARD_COUNT
  } guard_t;

  guard_t            guard_r,  guard_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic              kwd_r,    kwd_nxt;
  logic [TIME_W-1:0] last_r,   last_nxt;
  logic              awake_r,  awake_nxt;
  logic [TIME_W-1:0] start_r,  start_nxt;
  logic [1:0]        action_r, action_nxt;
  logic              off_r,    off_nxt;

  logic [CNT_W-1:0]  cnt_inc;
  logic [TIME_W-1:0] idle;
  logic              woke;
  logic [TIME_W-1:0] slept;

  always_comb begin
    guard_nxt  = guard_r;
    cnt_nxt    = cnt_r;
    kwd_nxt    = kwd_r;
    last_nxt   = last_r;
    awake_nxt  = awake_r;
    start_nxt  = start_r;
    action_nxt = action_r;
    off_nxt    = off_r;
    woke       = 1'b0;
    slept      = '0;
    idle       = '0;
    // saturate at full scale
    cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + 16'd1;

    if (!off_r) begin
      case (ev.req_type)
        REQ_INIT: begin
          guard_nxt = ev.key_down ? GUARD_WAIT : GUARD_COUNT;
          last_nxt  = ev.now_ms;
        end
        REQ_POLL: begin
          if (guard_r != GUARD_IGNORE) begin
            if (ev.key_down) begin
              if (guard_r == GUARD_COUNT) begin
                if (!kwd_r) begin
                  last_nxt = ev.now_ms;
                end
                cnt_nxt = cnt_inc;
                if (cnt_inc >= cfg.sleep_press_polls) begin
                  if (cnt_inc < cfg.restart_press_polls) begin
                    action_nxt = ACT_SLEEP;
                  end else if (cnt_inc < cfg.shutdown_press_polls) begin
                    action_nxt = ACT_RESTART;
                  end else begin
                    off_nxt   = 1'b1;
                    awake_nxt = 1'b0;
                    start_nxt = '0;
                  end
                end
              end
              kwd_nxt = 1'b1;
            end else begin
              // release arms counting after a key held at boot
              if (guard_r == GUARD_WAIT) begin
                guard_nxt = GUARD_COUNT;
              end
              cnt_nxt = '0;
              kwd_nxt = 1'b0;
            end
          end
          if (!off_nxt) begin
            idle = ev.now_ms - last_nxt;
            if (awake_r) begin
              if (idle > cfg.idle_timeout_ms) begin
                off_nxt   = 1'b1;
                awake_nxt = 1'b0;
                start_nxt = '0;
              end
            end else if (idle < WAKE_WINDOW_MS) begin
              woke      = 1'b1;
              slept     = ev.now_ms - start_r;
              awake_nxt = 1'b1;
              start_nxt = '0;
            end
          end
        end
        REQ_ACT: begin
          last_nxt = ev.now_ms;
        end
        REQ_SLEEP: begin
          awake_nxt = 1'b0;
          start_nxt = ev.now_ms;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r  <= GUARD_IGNORE;
      cnt_r    <= '0;
      kwd_r    <= 1'b0;
      last_r   <= '0;
      awake_r  <= 1'b1;
      start_r  <= '0;
      action_r <= ACT_NONE;
      off_r    <= 1'b0;
    end else if (fire) begin
      guard_r  <= guard_nxt;
      cnt_r    <= cnt_nxt;
      kwd_r    <= kwd_nxt;
      last_r   <= last_nxt;
      awake_r  <= awake_nxt;
      start_r  <= start_nxt;
      action_r <= action_nxt;
      off_r    <= off_nxt;
    end
  end

  assign res.display_on   = awake_nxt;
  assign res.shutdown     = off_nxt;
  assign res.press_action = action_nxt;
  assign res.woke         = woke;
  assign res.slept_ms     = slept;

endmodule

[src/pkc_out_stage.sv]
// -----------------------------------------------------------------------------
// Result output register
// Holds one result transaction until the consumer takes it.
// -----------------------------------------------------------------------------
module pkc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  pkc_pkg::result_t res,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output pkc_pkg::result_t res_q
);
  import pkc_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign load_ok = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule

[src/power_key_idle_controller.sv]
// -----------------------------------------------------------------------------
// Power key idle controller
// Long-press power key decoding with display sleep/wake and idle shutdown.
// -----------------------------------------------------------------------------
// Channel  | Direction | Carries
// in_ch    | sink      | req_type, now_ms, key_down
// out_ch   | source    | display_on, shutdown, press_action, woke, slept_ms
// cfg_*    | write     | cfg_index 0..3, cfg_data up to 32 bits
//
// One event per cycle sustained while results are taken; each accepted event
// passes through the input register, then decision logic into result register.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
// A stalled result holds the output register; the input register still takes
// one more event, then in_ch.ready drops until the result moves.
// -----------------------------------------------------------------------------
module power_key_idle_controller (
  input  logic        clk,
  input  logic        rst_n,
  pkc_in_if.sink      in_ch,
  pkc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pkc_pkg::*;

  cfg_t    cfg;
  event_t  ev_in;
  event_t  ev;
  logic    ev_valid;
  logic    advance;
  logic    load_ok;
  logic    in_ready;
  logic    out_valid;
  result_t res;
  result_t res_q;

  assign ev_in.req_type = in_ch.req_type;
  assign ev_in.now_ms   = in_ch.now_ms;
  assign ev_in.key_down = in_ch.key_down;

  // move the held event into the result register
  assign advance = ev_valid && load_ok;

  pkc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pkc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .ev_in    (ev_in),
    .advance  (advance),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  pkc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (advance),
    .ev    (ev),
    .res   (res)
  );

  pkc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res_q     (res_q)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.display_on   = res_q.display_on;
  assign out_ch.shutdown     = res_q.shutdown;
  assign out_ch.press_action = res_q.press_action;
  assign out_ch.woke         = res_q.woke;
  assign out_ch.slept_ms     = res_q.slept_ms;

endmodule

[src/pkc_checker.sv]
// -----------------------------------------------------------------------------
// Power key idle controller checker
// Port-level properties of the result stream, bound to the top level.
// -----------------------------------------------------------------------------
`include "power_key_idle_controller_macros.svh"

module pkc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        display_on,
  input logic        shutdown,
  input logic        woke,
  input logic [31:0] slept_ms
);

  logic off_seen_r;

  // remember that a shutdown result has gone out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_seen_r <= 1'b0;
    end else if (out_valid && out_ready && shutdown) begin
      off_seen_r <= 1'b1;
    end
  end

  `PKC_ASSERT_NOW(a_off_sticky, clk, rst_n, out_valid && off_seen_r, shutdown && !display_on, "shutdown dropped after latch")
  `PKC_ASSERT_NOW(a_woke_awake, clk, rst_n, out_valid && woke, display_on && !shutdown, "wake without display on")
  `PKC_ASSERT_NOW(a_slept_zero, clk, rst_n, out_valid && !woke, slept_ms == 32'd0, "sleep time without wake")
  `PKC_ASSERT_NEXT(a_out_hold, clk, rst_n, rst_n && out_valid && !out_ready, out_valid && $stable(slept_ms) && $stable(shutdown), "stalled result changed")

endmodule

bind power_key_idle_controller pkc_checker u_pkc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .display_on (out_ch.display_on),
  .shutdown   (out_ch.shutdown),
  .woke       (out_ch.woke),
  .slept_ms   (out_ch.slept_ms)
);

[tb/power_key_idle_controller_test.sv]
// -----------------------------------------------------------------------------
// Power key idle controller testbench
// Drives event transactions through the controller and checks every status
// transaction against a cycle-free model of the key guard, press counter,
// sleep/wake and shutdown latch. A short directed table comes first, then
// random press, sleep and activity sequences under several register settings
// and idling profiles. The run closes by forcing shutdown through a full-length
// press or an idle timeout, then confirms that later events are ignored.
// -----------------------------------------------------------------------------
module power_key_idle_controller_test;
  import pkc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned PIPE_LATENCY = 2;
  localparam int unsigned DRAIN_LIMIT  = 100000;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned PHASE_EVENTS = 250;
  localparam int unsigned SEND_IDLE [4] = '{0, 62, 0, 21};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 62, 21};

  typedef enum logic [1:0] {
    KEY_IGNORED      = 2'd0,
    KEY_WAIT_RELEASE = 2'd1,
    KEY_COUNTING     = 2'd2
  } key_guard_e;

  typedef struct packed {
    key_guard_e        guard;
    logic [CNT_W-1:0]  press_count;
    logic              key_was_down;
    logic [TIME_W-1:0] last_activity_ms;
    logic              awake;
    logic [TIME_W-1:0] sleep_start_ms;
    logic [1:0]        action_held;
    logic              off_latched;
  } ctl_state_t;

  typedef struct packed {
    event_t  ev;
    logic    typed;
    result_t status;
  } plan_row_t;

  localparam ctl_state_t CTL_RESET = '{guard: KEY_IGNORED, press_count: '0,
                                       key_was_down: 1'b0, last_activity_ms: '0,
                                       awake: 1'b1, sleep_start_ms: '0,
                                       action_held: ACT_NONE, off_latched: 1'b0};
  localparam cfg_t CFG_DEFAULTS = '{sleep_press_polls: 16'd2, restart_press_polls: 16'd6,
                                    shutdown_press_polls: 16'd10,
                                    idle_timeout_ms: 32'd60000};

  localparam logic    TYPED       = 1'b1;
  localparam logic    MODELED     = 1'b0;
  localparam result_t AWAKE_CLEAR = {1'b1, 1'b0, ACT_NONE, 1'b0, 32'd0};
  localparam result_t NO_STATUS   = '0;

  // Reset register values throughout
  localparam plan_row_t OPENING_PLAN [0:24] = '{
    {REQ_POLL,  32'd0,          1'b1, TYPED,   AWAKE_CLEAR}, // key ignored before init
    {REQ_ACT,   32'hFFFF_FFFF,  1'b0, TYPED,   AWAKE_CLEAR},
    {REQ_POLL,  32'd1000,       1'b1, TYPED,   AWAKE_CLEAR}, // idle wraps past zero
    {REQ_INIT,  32'd2000,       1'b1, TYPED,   AWAKE_CLEAR}, // held at boot
    {REQ_POLL,  32'd2100,       1'b1, MODELED, NO_STATUS},
    {REQ_POLL,  32'd2200,       1'b0, MODELED, NO_STATUS},   // release arms counting
    {REQ_POLL,  32'd2300,       1'b1, MODELED, NO_STATUS},
    {REQ_POLL,  32'd2400,       1'b1, MODELED, NO_STATUS},   // sleep request
    {REQ_SLEEP, 32'd2500,       1'b1, MODELED, NO_STATUS},
    {REQ_SLEEP, 32'd2600,       1'b0, MODELED, NO_STATUS},   // restamp while asleep
    {REQ_POLL,  32'd2700,       1'b1, MODELED, NO_STATUS},   // wake inside window
    {REQ_POLL,  32'd2800,       1'b1, MODELED, NO_STATUS},
    {REQ_POLL,  32'd2900,       1'b1, MODELED, NO_STATUS},
    {REQ_POLL,  32'd3000,       1'b1, MODELED, NO_STATUS},   // restart request
    {REQ_POLL,  32'd3100,       1'b0, MODELED, NO_STATUS},   // action stays sticky
    {REQ_SLEEP, 32'd3200,       1'b0, MODELED, NO_STATUS},
    {REQ_POLL,  32'd6000,       1'b0, MODELED, NO_STATUS},   // too late to wake
    {REQ_ACT,   32'd6100,       1'b1, MODELED, NO_STATUS},
    {REQ_POLL,  32'd8099,       1'b0, MODELED, NO_STATUS},   // last ms of window
    {REQ_SLEEP, 32'd8200,       1'b0, MODELED, NO_STATUS},
    {REQ_ACT,   32'd8300,       1'b0, MODELED, NO_STATUS},
    {REQ_POLL,  32'd10300,      1'b0, MODELED, NO_STATUS},   // window edge, stay dark
    {REQ_ACT,   32'hFFFF_FFF0,  1'b0, MODELED, NO_STATUS},
    {REQ_POLL,  32'd10,         1'b0, MODELED, NO_STATUS},   // slept time wraps
    {REQ_POLL,  32'd59984,      1'b0, MODELED, NO_STATUS}    // idle equals timeout
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pkc_in_if  in_ch ();
  pkc_out_if out_ch ();

  power_key_idle_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctl_state_t        ctl;
  cfg_t              cur_cfg;
  result_t           status_due [$];
  logic [TIME_W-1:0] clock_ms;
  bit                off_allowed;
  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       hold_left;
  int unsigned       events_in_phase;
  int unsigned       fail_count;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("power_key_idle_controller_test: FAIL");
    $finish;
  end

  function automatic void latch_off(inout ctl_state_t s);
    s.off_latched    = 1'b1;
    s.awake          = 1'b0;
    s.sleep_start_ms = '0;
  endfunction

  function automatic result_t step_power_state(inout ctl_state_t s, input cfg_t c,
                                               input event_t ev);
    result_t           r;
    logic [TIME_W-1:0] idle;
    r = '0;
    if (!s.off_latched) begin
      case (ev.req_type)
        REQ_INIT: begin
          s.guard            = ev.key_down ? KEY_WAIT_RELEASE : KEY_COUNTING;
          s.last_activity_ms = ev.now_ms;
        end
        REQ_POLL: begin
          if (s.guard != KEY_IGNORED) begin
            if (ev.key_down) begin
              if (s.guard == KEY_COUNTING) begin
                if (!s.key_was_down) s.last_activity_ms = ev.now_ms;
                if (s.press_count != '1) s.press_count = s.press_count + 1'b1;
                if (s.press_count >= c.sleep_press_polls) begin
                  if (s.press_count < c.restart_press_polls) s.action_held = ACT_SLEEP;
                  else if (s.press_count < c.shutdown_press_polls) s.action_held = ACT_RESTART;
                  else latch_off(s);
                end
              end
              s.key_was_down = 1'b1;
            end else begin
              if (s.guard == KEY_WAIT_RELEASE) s.guard = KEY_COUNTING;
              s.press_count  = '0;
              s.key_was_down = 1'b0;
            end
          end
          if (!s.off_latched) begin
            idle = ev.now_ms - s.last_activity_ms;
            if (s.awake) begin
              if (idle > c.idle_timeout_ms) latch_off(s);
            end else if (idle < WAKE_WINDOW_MS) begin
              r.woke           = 1'b1;
              r.slept_ms       = ev.now_ms - s.sleep_start_ms;
              s.awake          = 1'b1;
              s.sleep_start_ms = '0;
            end
          end
        end
        REQ_ACT: s.last_activity_ms = ev.now_ms;
        REQ_SLEEP: begin
          s.awake          = 1'b0;
          s.sleep_start_ms = ev.now_ms;
        end
        default: ;
      endcase
    end
    r.display_on   = s.awake;
    r.shutdown     = s.off_latched;
    r.press_action = s.action_held;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] pick_gap();
    case ($urandom_range(9, 0))
      0: return $urandom_range(1990, 2010);
      1: return $urandom();
      2: return '0;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // Offer one transaction; valid stays high on return so a back-to-back
  // transaction needs no second assignment in this step.
  task automatic push_event(input event_t ev, input logic typed, input result_t typed_status);
    result_t r;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= ev.req_type;
    in_ch.now_ms   <= ev.now_ms;
    in_ch.key_down <= ev.key_down;
    do @(posedge clk); while (!in_ch.ready);
    r = step_power_state(ctl, cur_cfg, ev);
    status_due.push_back(typed ? typed_status : r);
  endtask

  task automatic post_event(input logic [1:0] req, input logic key);
    event_t     ev;
    ctl_state_t probe;
    result_t    seen;
    ev.req_type = req;
    ev.now_ms   = clock_ms;
    ev.key_down = key;
    probe = ctl;
    seen  = step_power_state(probe, cur_cfg, ev);
    // keep the block alive until the closing phase: swap a fatal event for activity
    if (seen.shutdown && !off_allowed) ev.req_type = REQ_ACT;
    push_event(ev, MODELED, NO_STATUS);
    events_in_phase++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (status_due.size() != 0) begin
      $error("%0d status transactions never arrived", status_due.size());
      fail_count++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLEEP_POLLS;
    cfg_data  <= 32'(c.sleep_press_polls);
    @(posedge clk);
    cfg_index <= CFG_RESTART_POLLS;
    cfg_data  <= 32'(c.restart_press_polls);
    @(posedge clk);
    cfg_index <= CFG_SHUTDOWN_POLLS;
    cfg_data  <= 32'(c.shutdown_press_polls);
    @(posedge clk);
    cfg_index <= CFG_IDLE_TIMEOUT;
    cfg_data  <= c.idle_timeout_ms;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin : status_checker
    result_t got;
    result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.display_on   = out_ch.display_on;
        got.shutdown     = out_ch.shutdown;
        got.press_action = out_ch.press_action;
        got.woke         = out_ch.woke;
        got.slept_ms     = out_ch.slept_ms;
        if (status_due.size() == 0) begin
          $error("status transaction with none pending");
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (got.display_on !== want.display_on) begin
            $error("display_on: expected %0d, got %0d", want.display_on, got.display_on);
            fail_count++;
          end
          if (got.shutdown !== want.shutdown) begin
            $error("shutdown: expected %0d, got %0d", want.shutdown, got.shutdown);
            fail_count++;
          end
          if (got.press_action !== want.press_action) begin
            $error("press_action: expected %0d, got %0d", want.press_action,
                   got.press_action);
            fail_count++;
          end
          if (got.woke !== want.woke) begin
            $error("woke: expected %0d, got %0d", want.woke, got.woke);
            fail_count++;
          end
          if (got.slept_ms !== want.slept_ms) begin
            $error("slept_ms: expected %0d, got %0d", want.slept_ms, got.slept_ms);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    cfg_t        next_cfg;
    int unsigned kind;
    int unsigned presses;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_INIT;
    in_ch.now_ms   <= '0;
    in_ch.key_down <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SLEEP_POLLS;
    cfg_data       <= '0;
    ctl           = CTL_RESET;
    cur_cfg       = CFG_DEFAULTS;
    off_allowed   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    fail_count    = 0;
    clock_ms      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      push_event(OPENING_PLAN[i].ev, OPENING_PLAN[i].typed, OPENING_PLAN[i].status);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          next_cfg.sleep_press_polls    = 16'($urandom_range(1, 3));
          next_cfg.restart_press_polls  = next_cfg.sleep_press_polls + 16'($urandom_range(1, 4));
          next_cfg.shutdown_press_polls = next_cfg.restart_press_polls
                                          + 16'($urandom_range(1, 4));
          next_cfg.idle_timeout_ms      = $urandom_range(2000, 20000);
        end
        1: begin
          // thresholds in any order
          next_cfg.sleep_press_polls    = 16'($urandom_range(1, 12));
          next_cfg.restart_press_polls  = 16'($urandom_range(1, 12));
          next_cfg.shutdown_press_polls = 16'($urandom_range(1, 12));
          next_cfg.idle_timeout_ms      = $urandom_range(0, 3000);
        end
        2: next_cfg = '{sleep_press_polls: 16'd1, restart_press_polls: 16'd1,
                        shutdown_press_polls: 16'hFFFF, idle_timeout_ms: '0};
        3: next_cfg = '{sleep_press_polls: 16'hFFFF, restart_press_polls: 16'hFFFF,
                        shutdown_press_polls: 16'hFFFF, idle_timeout_ms: '1};
        4: begin
          next_cfg.sleep_press_polls    = 16'd1;
          next_cfg.restart_press_polls  = 16'hFFFF;
          next_cfg.shutdown_press_polls = 16'hFFFF;
          next_cfg.idle_timeout_ms      = $urandom();
        end
        default: next_cfg = CFG_DEFAULTS;
      endcase
      load_settings(next_cfg);
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct     = RECV_STALL[p % 4];
      clock_ms      = $urandom();
      // stall the results long enough to back up the input
      if (p % 4 == 0) hold_left = 80;
      events_in_phase = 0;
      while (events_in_phase < PHASE_EVENTS) begin
        kind = $urandom_range(99, 0);
        if (kind < 45) begin
          if ($urandom_range(9, 0) == 0) begin
            clock_ms += pick_gap();
            post_event(REQ_INIT, 1'($urandom_range(1, 0)));
          end
          presses = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 14);
          repeat (presses) begin
            clock_ms += 32'($urandom_range(0, 300));
            post_event(REQ_POLL, 1'b1);
          end
          repeat ($urandom_range(2, 1)) begin
            clock_ms += pick_gap();
            post_event(REQ_POLL, 1'b0);
          end
        end else if (kind < 65) begin
          clock_ms += pick_gap();
          post_event(REQ_SLEEP, 1'($urandom_range(1, 0)));
          if ($urandom_range(1, 0) == 1) begin
            clock_ms += pick_gap();
            post_event(REQ_ACT, 1'($urandom_range(1, 0)));
          end
          repeat ($urandom_range(3, 1)) begin
            clock_ms += pick_gap();
            post_event(REQ_POLL, 1'b0);
          end
        end else if (kind < 80) begin
          clock_ms += pick_gap();
          post_event(REQ_ACT, 1'($urandom_range(1, 0)));
          clock_ms += pick_gap();
          post_event(REQ_POLL, 1'($urandom_range(1, 0)));
        end else if (kind < 88) begin
          clock_ms += pick_gap();
          post_event(REQ_INIT, 1'($urandom_range(1, 0)));
        end else begin
          if ($urandom_range(3, 0) == 0) clock_ms = $urandom();
          else clock_ms += pick_gap();
          post_event(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
        end
        if ($urandom_range(49, 0) == 0) drain_results();
      end
    end

    // Closing phase: latch shutdown one way or the other
    if ($urandom_range(1, 0) == 1) begin
      load_settings('{sleep_press_polls: 16'd2, restart_press_polls: 16'd6,
                      shutdown_press_polls: 16'd10, idle_timeout_ms: '1});
      send_idle_pct = 0;
      stall_pct     = 0;
      off_allowed   = 1'b1;
      clock_ms     += 32'd10;
      post_event(REQ_INIT, 1'b0);
      // hold the key until the count reaches the shutdown threshold
      while (!ctl.off_latched) begin
        clock_ms += 32'd1;
        post_event(REQ_POLL, 1'b1);
      end
    end else begin
      next_cfg = '{sleep_press_polls: 16'hFFFF, restart_press_polls: 16'hFFFF,
                   shutdown_press_polls: 16'hFFFF,
                   idle_timeout_ms: 32'($urandom_range(0, 5000))};
      load_settings(next_cfg);
      send_idle_pct = 21;
      stall_pct     = 21;
      off_allowed   = 1'b1;
      clock_ms += 32'd10;
      post_event(REQ_ACT, 1'b0);
      clock_ms += 32'd1;
      post_event(REQ_POLL, 1'b0);
      for (int k = 0; k < 16 && !ctl.off_latched; k++) begin
        clock_ms += next_cfg.idle_timeout_ms / 2 + 1;
        post_event(REQ_POLL, 1'b0);
      end
    end
    send_idle_pct = 21;
    stall_pct     = 21;
    for (int k = 0; k < 12; k++) begin
      clock_ms += pick_gap();
      post_event(2'(k % 4), 1'($urandom_range(1, 0)));
    end

    drain_results();
    if (fail_count == 0) begin
      $display("power_key_idle_controller_test: PASS");
    end else begin
      $display("power_key_idle_controller_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pkc_pkg.sv
src/pkc_if.sv
src/pkc_cfg_regs.sv
src/pkc_in_stage.sv
src/pkc_core.sv
src/pkc_out_stage.sv
src/power_key_idle_controller.sv
src/pkc_checker.sv
tb/power_key_idle_controller_test.sv
